/* design/tphd_pkg.sv */
// Shared types and constants for the touch press button hit detector.
// No dependencies; imported by the cell, the top level and the testbench.
`default_nettype none

package tphd_pkg;

    // Default sizes handed to the top level parameters.
    localparam int TABLE_DEPTH_DEF = 16;
    localparam int RAW_BITS_DEF    = 12;

    // Calibration of the raw sensor range.
    localparam int RAW_MIN_X = 150;
    localparam int RAW_MIN_Y = 130;
    localparam int RAW_MAX   = 3600;

    // Register reset values.
    localparam logic [9:0]  SCREEN_WIDTH_RST  = 10'd320;
    localparam logic [9:0]  SCREEN_HEIGHT_RST = 10'd240;
    localparam logic [4:0]  BUTTON_COUNT_RST  = 5'd0;
    localparam logic [7:0]  RELEASE_TICKS_RST = 8'd35;
    localparam logic [31:0] SAVER_TIMEOUT_RST = 32'd0;

    // One table write, broadcast along the row of cells.
    typedef struct packed {
        logic       en;
        logic [3:0] entry_index;
        logic [9:0] left;
        logic [9:0] top;
        logic [9:0] width;
        logic [9:0] height;
        logic       active;
    } tbl_wr_t;

    // Control bits of a search probe travelling through the cells.
    typedef struct packed {
        logic valid;
        logic found;
    } probe_ctl_t;

endpackage

`default_nettype wire

/* design/tphd_scale.sv */
// Four-stage scaler of one raw touch axis to screen pixels, truncating toward zero.
// Uses a reciprocal multiply with one correction step; depends on nothing else.
`default_nettype none

module tphd_scale #(
    parameter int RAW_BITS = 12,
    parameter int LO       = 150,
    parameter int DIVISOR  = 3450,
    parameter int CW       = 14
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [RAW_BITS-1:0]  raw,
    input  wire logic [9:0]           size,
    output logic                      done,
    output logic signed [CW-1:0]      coord
);

    localparam int MW = RAW_BITS + 10;
    localparam int DW = $clog2(DIVISOR + 1);
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / DIVISOR);

    logic signed [RAW_BITS:0] diff;
    logic [RAW_BITS-1:0]      absd;
    logic [MW+31:0]           recip_prod;
    logic [MW+DW-1:0]         back_prod;
    logic [MW-1:0]            rem;
    logic [MW-1:0]            q_fix;
    logic [CW-1:0]            q_cut;

    logic          v1_reg, v2_reg, v3_reg, v4_reg;
    logic          neg1_reg, neg2_reg, neg3_reg;
    logic [MW-1:0] m1_reg, m2_reg, m3_reg;
    logic [MW-1:0] q2_reg, q3_reg, qd3_reg;
    logic signed [CW-1:0] coord_reg;

    assign diff       = $signed({1'b0, raw}) - $signed((RAW_BITS + 1)'(LO));
    assign absd       = diff[RAW_BITS] ? RAW_BITS'(-diff) : diff[RAW_BITS-1:0];
    assign recip_prod = MW'(m1_reg) * (MW + 32)'(RECIP);
    assign back_prod  = (MW + DW)'(q2_reg) * (MW + DW)'(DIVISOR);
    assign rem        = m3_reg - qd3_reg;
    assign q_fix      = (rem >= MW'(DIVISOR)) ? q3_reg + MW'(1) : q3_reg;
    assign q_cut      = q_fix[CW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        neg1_reg  <= diff[RAW_BITS];
        m1_reg    <= MW'(absd) * MW'(size);
        neg2_reg  <= neg1_reg;
        m2_reg    <= m1_reg;
        q2_reg    <= recip_prod[MW+31:32];
        neg3_reg  <= neg2_reg;
        m3_reg    <= m2_reg;
        q3_reg    <= q2_reg;
        qd3_reg   <= back_prod[MW-1:0];
        coord_reg <= neg3_reg ? -$signed(q_cut) : $signed(q_cut);
    end

    assign done  = v4_reg;
    assign coord = coord_reg;

endmodule

`default_nettype wire

/* design/tphd_cell.sv */
// One cell of the button row: holds one table entry and tests a passing probe.
// Depends on tphd_pkg for the write request and probe control structs.
`default_nettype none

module tphd_cell #(
    parameter int CELL_ID = 0,
    parameter int CW      = 14,
    parameter int IW      = 4
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  tphd_pkg::tbl_wr_t         wr,
    input  wire logic [4:0]           count,
    input  tphd_pkg::probe_ctl_t      ctl_in,
    input  wire logic signed [CW-1:0] x_in,
    input  wire logic signed [CW-1:0] y_in,
    input  wire logic [IW-1:0]        idx_in,
    output tphd_pkg::probe_ctl_t      ctl_out,
    output logic signed [CW-1:0]      x_out,
    output logic signed [CW-1:0]      y_out,
    output logic [IW-1:0]             idx_out
);

    import tphd_pkg::*;

    logic [9:0] left_reg, top_reg, wid_reg, hgt_reg;
    logic       active_reg;

    logic       wr_here;
    logic       searched;
    logic       hit_here;
    logic signed [CW-1:0] left_s, right_s, top_s, bottom_s;

    probe_ctl_t           ctl_reg, ctl_next;
    logic signed [CW-1:0] x_reg, y_reg;
    logic [IW-1:0]        idx_reg, idx_next;

    assign wr_here  = wr.en && (CELL_ID < 16) && (wr.entry_index == 4'(CELL_ID));
    assign searched = (CELL_ID < 32) && (5'(CELL_ID) < count);

    assign left_s   = $signed(CW'(left_reg));
    assign right_s  = $signed(CW'({1'b0, left_reg} + {1'b0, wid_reg}));
    assign top_s    = $signed(CW'(top_reg));
    assign bottom_s = $signed(CW'({1'b0, top_reg} + {1'b0, hgt_reg}));

    assign hit_here = ctl_in.valid && !ctl_in.found && searched && active_reg
                      && (x_in > left_s) && (x_in < right_s)
                      && (y_in > top_s) && (y_in < bottom_s);

    always_comb
    begin
        ctl_next.valid = ctl_in.valid;
        ctl_next.found = ctl_in.found || hit_here;
        idx_next       = hit_here ? IW'(CELL_ID) : idx_in;
    end

    // Table contents have no reset: they are defined once written.
    always_ff @(posedge clk)
    begin
        if (wr_here)
        begin
            left_reg   <= wr.left;
            top_reg    <= wr.top;
            wid_reg    <= wr.width;
            hgt_reg    <= wr.height;
            active_reg <= wr.active;
        end
        x_reg   <= x_in;
        y_reg   <= y_in;
        idx_reg <= idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign idx_out = idx_reg;

endmodule

`default_nettype wire

/* design/touch_press_button_hit_detector_top.sv */
// Top level of the touch press button hit detector: control, registers, output stage.
// A table write gives no result; a sample that does not start a press gives its result
// in the cycle after acceptance. A new press passes the four scaling stages, one
// register per cell, the result capture and the output register; no new request is
// taken until its result has been handed to the output register.
// Reset: control state and registers return to defaults; table contents stay undefined.
`default_nettype none

module touch_press_button_hit_detector_top #(
    parameter int TABLE_DEPTH = tphd_pkg::TABLE_DEPTH_DEF,
    parameter int RAW_BITS    = tphd_pkg::RAW_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    // Request channel.
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic                cmd,
    input  wire logic [3:0]          entry_index,
    input  wire logic [9:0]          rect_left,
    input  wire logic [9:0]          rect_top,
    input  wire logic [9:0]          rect_width,
    input  wire logic [9:0]          rect_height,
    input  wire logic                entry_active,
    input  wire logic                touched,
    input  wire logic [RAW_BITS-1:0] raw_x,
    input  wire logic [RAW_BITS-1:0] raw_y,
    // Result channel.
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic                     press_start,
    output logic                     hit,
    output logic [3:0]               button_index,
    output logic                     saver_on,
    output logic                     woke,
    // Configuration write port.
    input  wire logic                cfg_we,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [31:0]         cfg_data
);

    import tphd_pkg::*;

    // Coordinates must hold the scaled point and the far edge of a rectangle.
    localparam int CW = (RAW_BITS + 1 > 12) ? RAW_BITS + 1 : 12;
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
    localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd1;
    localparam logic [2:0] REG_BUTTON_COUNT  = 3'd2;
    localparam logic [2:0] REG_RELEASE_TICKS = 3'd3;
    localparam logic [2:0] REG_SAVER_TIMEOUT = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_BUSY = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    // Configuration registers.
    logic [9:0]  screen_width_reg, screen_height_reg;
    logic [4:0]  button_count_reg;
    logic [7:0]  release_ticks_reg;
    logic [31:0] saver_timeout_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= SCREEN_WIDTH_RST;
            screen_height_reg <= SCREEN_HEIGHT_RST;
            button_count_reg  <= BUTTON_COUNT_RST;
            release_ticks_reg <= RELEASE_TICKS_RST;
            saver_timeout_reg <= SAVER_TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data[9:0];
                REG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[9:0];
                REG_BUTTON_COUNT:  button_count_reg  <= cfg_data[4:0];
                REG_RELEASE_TICKS: release_ticks_reg <= cfg_data[7:0];
                REG_SAVER_TIMEOUT: saver_timeout_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Press and screensaver state.
    state_t      state_reg, state_next;
    logic        press_held_reg, press_held_next;
    logic [7:0]  idle_ticks_reg, idle_ticks_next;
    logic [31:0] saver_ticks_reg, saver_ticks_next;
    logic        saver_flag_reg, saver_flag_next;

    // Search result captured at the end of the cell row.
    logic          res_found_reg, res_found_next;
    logic [IW-1:0] res_idx_reg, res_idx_next;

    // Output register.
    logic       out_valid_reg, out_valid_next;
    logic       press_start_reg, press_start_next;
    logic       hit_reg, hit_next;
    logic [3:0] button_index_reg, button_index_next;
    logic       saver_on_reg, saver_on_next;
    logic       woke_reg, woke_next;

    logic        out_free;
    logic        in_accept;
    logic        load_imm;
    logic        woke_imm;
    logic        scan_start;
    logic        load_done;
    logic [8:0]  gap;
    logic [31:0] tick_inc;
    logic [IW+3:0] idx_wide;

    // The output register is free when empty or being taken this cycle. A request is
    // taken only while no press search is running and the output can take a result.
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = !((state_reg == ST_IDLE) && out_free);
    assign in_accept = in_valid && !in_stall;

    assign gap      = {1'b0, idle_ticks_reg} + 9'd1;
    assign tick_inc = (saver_ticks_reg != '1) ? saver_ticks_reg + 32'd1 : saver_ticks_reg;

    // Table write request, seen by every cell; the cell with the matching slot stores it.
    tbl_wr_t wr;

    always_comb
    begin
        wr.en          = in_accept && (cmd == CMD_WRITE);
        wr.entry_index = entry_index;
        wr.left        = rect_left;
        wr.top         = rect_top;
        wr.width       = rect_width;
        wr.height      = rect_height;
        wr.active      = entry_active;
    end

    // Sample handling. Everything except the button search is settled at acceptance.
    always_comb
    begin
        press_held_next  = press_held_reg;
        idle_ticks_next  = idle_ticks_reg;
        saver_ticks_next = saver_ticks_reg;
        saver_flag_next  = saver_flag_reg;
        load_imm         = 1'b0;
        woke_imm         = 1'b0;
        scan_start       = 1'b0;
        if (in_accept && (cmd == CMD_SAMPLE))
        begin
            if (touched)
            begin
                saver_ticks_next = '0;
                if (saver_flag_reg)
                begin
                    // This touch only wakes the block.
                    saver_flag_next = 1'b0;
                    woke_imm        = 1'b1;
                    load_imm        = 1'b1;
                end
                else
                begin
                    idle_ticks_next = '0;
                    if (press_held_reg)
                    begin
                        load_imm = 1'b1;
                    end
                    else
                    begin
                        press_held_next = 1'b1;
                        scan_start      = 1'b1;
                    end
                end
            end
            else
            begin
                load_imm = 1'b1;
                if (press_held_reg)
                begin
                    if (gap > {1'b0, release_ticks_reg})
                    begin
                        press_held_next = 1'b0;
                        idle_ticks_next = '0;
                    end
                    else
                    begin
                        idle_ticks_next = gap[7:0];
                    end
                end
                if (saver_timeout_reg != '0)
                begin
                    if (tick_inc >= saver_timeout_reg)
                    begin
                        saver_flag_next  = 1'b1;
                        saver_ticks_next = '0;
                    end
                    else
                    begin
                        saver_ticks_next = tick_inc;
                    end
                end
            end
        end
    end

    // Scaling of the new press point, one scaler per axis.
    logic                 x_done, y_done;
    logic signed [CW-1:0] x_coord, y_coord;

    tphd_scale #(
        .RAW_BITS (RAW_BITS),
        .LO       (RAW_MIN_X),
        .DIVISOR  (RAW_MAX - RAW_MIN_X),
        .CW       (CW)
    ) u_scale_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (scan_start),
        .raw   (raw_x),
        .size  (screen_width_reg),
        .done  (x_done),
        .coord (x_coord)
    );

    tphd_scale #(
        .RAW_BITS (RAW_BITS),
        .LO       (RAW_MIN_Y),
        .DIVISOR  (RAW_MAX - RAW_MIN_Y),
        .CW       (CW)
    ) u_scale_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (scan_start),
        .raw   (raw_y),
        .size  (screen_height_reg),
        .done  (y_done),
        .coord (y_coord)
    );

    // Row of cells. The probe enters cell 0 and moves one cell per cycle; the first
    // searched, active cell that contains the point marks it found and stamps its slot.
    probe_ctl_t           chain_ctl [TABLE_DEPTH+1];
    logic signed [CW-1:0] chain_x   [TABLE_DEPTH+1];
    logic signed [CW-1:0] chain_y   [TABLE_DEPTH+1];
    logic [IW-1:0]        chain_idx [TABLE_DEPTH+1];
    logic [TABLE_DEPTH:0] chain_valid;

    always_comb
    begin
        chain_ctl[0].valid = x_done && y_done;
        chain_ctl[0].found = 1'b0;
        chain_x[0]         = x_coord;
        chain_y[0]         = y_coord;
        chain_idx[0]       = '0;
    end

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        tphd_cell #(
            .CELL_ID (i),
            .CW      (CW),
            .IW      (IW)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .wr      (wr),
            .count   (button_count_reg),
            .ctl_in  (chain_ctl[i]),
            .x_in    (chain_x[i]),
            .y_in    (chain_y[i]),
            .idx_in  (chain_idx[i]),
            .ctl_out (chain_ctl[i+1]),
            .x_out   (chain_x[i+1]),
            .y_out   (chain_y[i+1]),
            .idx_out (chain_idx[i+1])
        );
    end

    for (genvar i = 0; i <= TABLE_DEPTH; i++)
    begin : g_valid
        assign chain_valid[i] = chain_ctl[i].valid;
    end

    // Sequencer: wait for the probe to leave the row, then hand the result over.
    always_comb
    begin
        state_next     = state_reg;
        res_found_next = res_found_reg;
        res_idx_next   = res_idx_reg;
        load_done      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (scan_start)
                begin
                    state_next = ST_BUSY;
                end
            end
            ST_BUSY:
            begin
                if (chain_ctl[TABLE_DEPTH].valid)
                begin
                    res_found_next = chain_ctl[TABLE_DEPTH].found;
                    res_idx_next   = chain_idx[TABLE_DEPTH];
                    state_next     = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    load_done  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The slot number is reported in four bits whatever the table depth.
    assign idx_wide = {4'b0, res_idx_reg};

    always_comb
    begin
        press_start_next  = press_start_reg;
        hit_next          = hit_reg;
        button_index_next = button_index_reg;
        saver_on_next     = saver_on_reg;
        woke_next         = woke_reg;
        if (load_imm)
        begin
            out_valid_next    = 1'b1;
            press_start_next  = 1'b0;
            hit_next          = 1'b0;
            button_index_next = '0;
            saver_on_next     = saver_flag_next;
            woke_next         = woke_imm;
        end
        else if (load_done)
        begin
            out_valid_next    = 1'b1;
            press_start_next  = 1'b1;
            hit_next          = res_found_reg;
            button_index_next = idx_wide[3:0];
            saver_on_next     = saver_flag_reg;
            woke_next         = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            press_held_reg  <= 1'b0;
            idle_ticks_reg  <= '0;
            saver_ticks_reg <= '0;
            saver_flag_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            press_held_reg  <= press_held_next;
            idle_ticks_reg  <= idle_ticks_next;
            saver_ticks_reg <= saver_ticks_next;
            saver_flag_reg  <= saver_flag_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_found_reg    <= res_found_next;
        res_idx_reg      <= res_idx_next;
        press_start_reg  <= press_start_next;
        hit_reg          <= hit_next;
        button_index_reg <= button_index_next;
        saver_on_reg     <= saver_on_next;
        woke_reg         <= woke_next;
    end

    assign out_valid    = out_valid_reg;
    assign press_start  = press_start_reg;
    assign hit          = hit_reg;
    assign button_index = button_index_reg;
    assign saver_on     = saver_on_reg;
    assign woke         = woke_reg;

    // Only one press search can be under way at any time.
    a_single_probe: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(chain_valid) <= 1)
        else $error("more than one probe in the cell row");

    // A probe leaves the row only while the sequencer waits for it.
    a_exit_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        chain_ctl[TABLE_DEPTH].valid |-> state_reg == ST_BUSY)
        else $error("probe left the row outside a search");

    // Untouched samples are counted only during a held press.
    a_idle_needs_press: assert property (@(posedge clk) disable iff (!rst_n)
        idle_ticks_reg != '0 |-> press_held_reg)
        else $error("idle count without a held press");

    // A new press always starts a search and holds off further requests.
    a_press_starts_search: assert property (@(posedge clk) disable iff (!rst_n)
        scan_start |=> (state_reg == ST_BUSY) && press_held_reg)
        else $error("new press did not start a search");

endmodule

`default_nettype wire

/* sim/touch_press_button_hit_detector_top_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the touch press button hit detector top level.
// Depends on tphd_pkg and touch_press_button_hit_detector_top from the design folder.

module touch_press_button_hit_detector_top_test;

    import tphd_pkg::*;

    localparam int DEPTH    = TABLE_DEPTH_DEF;
    localparam int RAW_W    = RAW_BITS_DEF;
    // Settling time is twice the cost of one new press, which covers any tail.
    localparam int SETTLE   = 2 * (DEPTH + 6);
    localparam int LIMIT    = 2_000_000;
    localparam int ITEMS_PER_PHASE = 225;

    // Request commands.
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // Configuration register indexes.
    localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
    localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd1;
    localparam logic [2:0] REG_BUTTON_COUNT  = 3'd2;
    localparam logic [2:0] REG_RELEASE_TICKS = 3'd3;
    localparam logic [2:0] REG_SAVER_TIMEOUT = 3'd4;

    typedef enum logic [1:0] {
        IDLE_NONE     = 2'd0,
        IDLE_SENDER   = 2'd1,
        IDLE_RECEIVER = 2'd2,
        IDLE_BOTH     = 2'd3
    } idle_mode_e;

    // One request as the driver presents it. The drain bit is not a port: it makes the
    // driver hold this request back until every outstanding result has come out.
    typedef struct packed {
        logic             cmd;
        logic [3:0]       entry_index;
        logic [9:0]       left;
        logic [9:0]       top;
        logic [9:0]       wid;
        logic [9:0]       hgt;
        logic             active;
        logic             touched;
        logic [RAW_W-1:0] raw_x;
        logic [RAW_W-1:0] raw_y;
        logic             drain;
    } touch_req_t;

    typedef struct packed {
        logic       press_start;
        logic       hit;
        logic [3:0] button_index;
        logic       saver_on;
        logic       woke;
    } touch_report_t;

    // Clock, reset and every block input start at known values.
    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             in_valid     = 1'b0;
    logic             in_stall;
    logic             cmd          = 1'b0;
    logic [3:0]       entry_index  = '0;
    logic [9:0]       rect_left    = '0;
    logic [9:0]       rect_top     = '0;
    logic [9:0]       rect_width   = '0;
    logic [9:0]       rect_height  = '0;
    logic             entry_active = 1'b0;
    logic             touched      = 1'b0;
    logic [RAW_W-1:0] raw_x        = '0;
    logic [RAW_W-1:0] raw_y        = '0;
    logic             out_valid;
    logic             out_stall    = 1'b0;
    logic             press_start;
    logic             hit;
    logic [3:0]       button_index;
    logic             saver_on;
    logic             woke;
    logic             cfg_we       = 1'b0;
    logic [2:0]       cfg_index    = '0;
    logic [31:0]      cfg_data     = '0;

    touch_press_button_hit_detector_top dut (.*);

    always #10 clk = ~clk;

    // Requests waiting to be driven, and results the predictor has worked out.
    touch_req_t    touch_reqs[$];
    touch_report_t expected_reports[$];
    touch_req_t    in_flight;
    int            n_queued    = 0;
    int            n_accepted  = 0;
    int            mismatches  = 0;
    int            cycle_count = 0;
    bit            force_drain = 1'b0;
    idle_mode_e    idle_mode   = IDLE_NONE;

    // Predictor state: its own copy of the button table, press tracking,
    // screensaver tracking and configuration.
    logic [9:0]  tbl_left[DEPTH];
    logic [9:0]  tbl_top[DEPTH];
    logic [9:0]  tbl_wid[DEPTH];
    logic [9:0]  tbl_hgt[DEPTH];
    logic        tbl_active[DEPTH];
    logic        held_press  = 1'b0;
    logic [7:0]  idle_count  = '0;
    logic [31:0] saver_count = '0;
    logic        saver_lit   = 1'b0;
    logic [9:0]  cfg_width   = SCREEN_WIDTH_RST;
    logic [9:0]  cfg_height  = SCREEN_HEIGHT_RST;
    logic [4:0]  cfg_count   = BUTTON_COUNT_RST;
    logic [7:0]  cfg_release = RELEASE_TICKS_RST;
    logic [31:0] cfg_saver   = SAVER_TIMEOUT_RST;

    // The stimulus side keeps a shadow of what it has written so that it can aim
    // touches into buttons; it runs ahead of the predictor's table.
    int aim_left[DEPTH];
    int aim_top[DEPTH];
    int aim_wid[DEPTH];
    int aim_hgt[DEPTH];

    function automatic bit roll(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // Applies one accepted request to the predictor state. Returns 1 when the request
    // produces a result, which is then left in rep.
    function automatic bit predict_report(input touch_req_t r, output touch_report_t rep);
        int x;
        int y;
        int n;
        int i;
        bit found;
        rep   = '0;
        found = 1'b0;
        if (r.cmd == CMD_WRITE)
        begin
            tbl_left[r.entry_index]   = r.left;
            tbl_top[r.entry_index]    = r.top;
            tbl_wid[r.entry_index]    = r.wid;
            tbl_hgt[r.entry_index]    = r.hgt;
            tbl_active[r.entry_index] = r.active;
            return 1'b0;
        end
        if (r.touched)
        begin
            saver_count = '0;
            // A touch during the screensaver only wakes; the press state is left alone.
            if (saver_lit)
            begin
                saver_lit = 1'b0;
                rep.woke  = 1'b1;
                return 1'b1;
            end
            idle_count = '0;
            if (held_press)
                return 1'b1;
            held_press = 1'b1;
            // Signed scaling with truncation toward zero; the point may be negative
            // or lie beyond the screen.
            x = ((int'(r.raw_x) - RAW_MIN_X) * int'(cfg_width)) / (RAW_MAX - RAW_MIN_X);
            y = ((int'(r.raw_y) - RAW_MIN_Y) * int'(cfg_height)) / (RAW_MAX - RAW_MIN_Y);
            n = (int'(cfg_count) > DEPTH) ? DEPTH : int'(cfg_count);
            rep.press_start = 1'b1;
            for (i = 0; i < n && !found; i++)
            begin
                if (tbl_active[i] &&
                    x > int'(tbl_left[i]) && x < int'(tbl_left[i]) + int'(tbl_wid[i]) &&
                    y > int'(tbl_top[i]) && y < int'(tbl_top[i]) + int'(tbl_hgt[i]))
                begin
                    found            = 1'b1;
                    rep.hit          = 1'b1;
                    rep.button_index = 4'(i);
                end
            end
            return 1'b1;
        end
        // Untouched sample: count toward release and toward the screensaver.
        if (held_press)
        begin
            if (int'(idle_count) + 1 > int'(cfg_release))
            begin
                held_press = 1'b0;
                idle_count = '0;
            end
            else
            begin
                idle_count = idle_count + 8'd1;
            end
        end
        if (cfg_saver != '0)
        begin
            if (saver_count != 32'hFFFF_FFFF)
                saver_count = saver_count + 32'd1;
            if (saver_count >= cfg_saver)
            begin
                saver_lit   = 1'b1;
                saver_count = '0;
            end
        end
        rep.saver_on = saver_lit;
        return 1'b1;
    endfunction

    function automatic void check_field(string name, logic [3:0] want, logic [3:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s differs, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Request driver. A request stays on the bus until accepted; the next one may
    // follow in the cycle after acceptance. The sender idles at random according to idle_mode.
    always @(posedge clk)
    begin : request_driver
        touch_report_t rep;
        bit            taken;
        bit            gap;
        if (rst_n)
        begin
            taken = in_valid && !in_stall;
            if (taken)
            begin
                if (predict_report(in_flight, rep))
                    expected_reports.push_back(rep);
                n_accepted++;
            end
            if (!in_valid || taken)
            begin
                gap = (idle_mode == IDLE_SENDER && roll(84)) ||
                      (idle_mode == IDLE_BOTH && roll(24));
                if (touch_reqs.size() != 0 && !gap &&
                    !(touch_reqs[0].drain && expected_reports.size() != 0))
                begin
                    in_flight     = touch_reqs.pop_front();
                    cmd          <= in_flight.cmd;
                    entry_index  <= in_flight.entry_index;
                    rect_left    <= in_flight.left;
                    rect_top     <= in_flight.top;
                    rect_width   <= in_flight.wid;
                    rect_height  <= in_flight.hgt;
                    entry_active <= in_flight.active;
                    touched      <= in_flight.touched;
                    raw_x        <= in_flight.raw_x;
                    raw_y        <= in_flight.raw_y;
                    in_valid     <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compares every accepted result with the oldest expectation
    // and stalls the result channel at random according to idle_mode.
    always @(posedge clk)
    begin : result_monitor
        touch_report_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_reports.size() == 0)
                begin
                    $display("%0t ns: result with none expected, actual %b%b%0d%b%b", $time,
                             press_start, hit, button_index, saver_on, woke);
                    mismatches++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    check_field("press_start", 4'(want.press_start), 4'(press_start));
                    check_field("hit", 4'(want.hit), 4'(hit));
                    check_field("button_index", want.button_index, button_index);
                    check_field("saver_on", 4'(want.saver_on), 4'(saver_on));
                    check_field("woke", 4'(want.woke), 4'(woke));
                end
            end
            out_stall <= (idle_mode == IDLE_RECEIVER && roll(84)) ||
                         (idle_mode == IDLE_BOTH && roll(24));
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == LIMIT)
        begin
            $display("%0t ns: timeout with %0d results outstanding", $time,
                     expected_reports.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Every request carries random values in the fields its command ignores, so
    // all input bits toggle. Now and then a request waits for the pipeline to drain.
    function automatic touch_req_t noise_req();
        touch_req_t r;
        r.cmd         = CMD_SAMPLE;
        r.entry_index = 4'($urandom_range(0, 15));
        r.left        = 10'($urandom_range(0, 1023));
        r.top         = 10'($urandom_range(0, 1023));
        r.wid         = 10'($urandom_range(0, 1023));
        r.hgt         = 10'($urandom_range(0, 1023));
        r.active      = 1'($urandom_range(0, 1));
        r.touched     = 1'($urandom_range(0, 1));
        r.raw_x       = RAW_W'($urandom_range(0, 4095));
        r.raw_y       = RAW_W'($urandom_range(0, 4095));
        r.drain       = 1'b0;
        return r;
    endfunction

    task automatic queue_req(input touch_req_t r);
        r.drain     = force_drain || roll(1);
        force_drain = 1'b0;
        touch_reqs.push_back(r);
        n_queued++;
    endtask

    task automatic queue_write(input int idx, input int l, input int t, input int w,
                               input int h, input bit act);
        touch_req_t r;
        r             = noise_req();
        r.cmd         = CMD_WRITE;
        r.entry_index = 4'(idx);
        r.left        = 10'(l);
        r.top         = 10'(t);
        r.wid         = 10'(w);
        r.hgt         = 10'(h);
        r.active      = act;
        aim_left[idx] = l;
        aim_top[idx]  = t;
        aim_wid[idx]  = w;
        aim_hgt[idx]  = h;
        queue_req(r);
    endtask

    task automatic queue_sample(input bit t, input int rx, input int ry);
        touch_req_t r;
        r         = noise_req();
        r.cmd     = CMD_SAMPLE;
        r.touched = t;
        r.raw_x   = RAW_W'(rx);
        r.raw_y   = RAW_W'(ry);
        queue_req(r);
    endtask

    // Smallest raw reading that scales to pixel px, clipped to the sensor range.
    function automatic int aim_raw(int px, int size, int lo);
        int raw;
        raw = lo + (px * (RAW_MAX - lo) + size - 1) / size;
        return (raw > 4095) ? 4095 : raw;
    endfunction

    // Waits until every request is accepted and every result has come out, then lets
    // a table write that produced no result finish inside the block.
    task automatic wait_idle();
        while (n_accepted != n_queued || expected_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_SCREEN_WIDTH:  cfg_width   = val[9:0];
            REG_SCREEN_HEIGHT: cfg_height  = val[9:0];
            REG_BUTTON_COUNT:  cfg_count   = val[4:0];
            REG_RELEASE_TICKS: cfg_release = val[7:0];
            REG_SAVER_TIMEOUT: cfg_saver   = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_setting(input int w, input int h, input int bc, input int rel,
                                 input logic [31:0] sv, input idle_mode_e m);
        wait_idle();
        write_reg(REG_SCREEN_WIDTH, 32'(w));
        write_reg(REG_SCREEN_HEIGHT, 32'(h));
        write_reg(REG_BUTTON_COUNT, 32'(bc));
        write_reg(REG_RELEASE_TICKS, 32'(rel));
        write_reg(REG_SAVER_TIMEOUT, sv);
        idle_mode = m;
    endtask

    // Random traffic. Most of it is whole presses: a first touch, often aimed into a
    // button, a few held touches, then enough untouched samples to release. The rest
    // is table rewrites, lone noise samples and presses cut short before release.
    task automatic run_random_phase(input int n_items);
        int made;
        int k;
        int gap;
        int i;
        int tgt;
        int w;
        int h;
        made = 0;
        w    = int'(cfg_width);
        h    = int'(cfg_height);
        while (made < n_items)
        begin
            if (roll(8))
            begin
                if (roll(50))
                    queue_write($urandom_range(0, 15), $urandom_range(0, 1023),
                                $urandom_range(0, 1023), $urandom_range(0, 1023),
                                $urandom_range(0, 1023), roll(70));
                else
                    queue_write($urandom_range(0, 15), $urandom_range(0, w - 1),
                                $urandom_range(0, h - 1), $urandom_range(0, w),
                                $urandom_range(0, h), roll(70));
                made++;
            end
            else if (roll(9))
            begin
                queue_sample(roll(50), $urandom_range(0, 4095), $urandom_range(0, 4095));
                made++;
            end
            else
            begin
                k   = $urandom_range(1, 4);
                tgt = $urandom_range(0, 15);
                for (i = 0; i < k; i++)
                begin
                    if (i == 0 && roll(70) && aim_wid[tgt] >= 2 && aim_hgt[tgt] >= 2)
                        queue_sample(1'b1,
                            aim_raw(aim_left[tgt] + 1 + $urandom_range(0, aim_wid[tgt] - 2),
                                    w, RAW_MIN_X),
                            aim_raw(aim_top[tgt] + 1 + $urandom_range(0, aim_hgt[tgt] - 2),
                                    h, RAW_MIN_Y));
                    else
                        queue_sample(1'b1, $urandom_range(0, 4095), $urandom_range(0, 4095));
                end
                if (roll(25))
                    gap = $urandom_range(0, int'(cfg_release));
                else
                    gap = int'(cfg_release) + 1 + $urandom_range(0, 2);
                for (i = 0; i < gap; i++)
                    queue_sample(1'b0, $urandom_range(0, 4095), $urandom_range(0, 4095));
                made += k + gap;
            end
        end
    endtask

    initial
    begin : stimulus
        int p;
        int i;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Reset configuration, nothing searched yet: presses at the raw extremes,
        // a held touch and an untouched sample that does not release.
        queue_sample(1'b1, 0, 0);
        queue_sample(1'b1, 4095, 4095);
        queue_sample(1'b0, 2048, 2048);
        queue_sample(1'b1, RAW_MIN_X, RAW_MIN_Y);

        // Fill the whole table before any search can read it. Entry 0 is an inactive
        // full-screen button, entry 1 a small active one, entry 2 an active catch-all,
        // entry 15 sits at the field maxima.
        queue_write(0, 0, 0, 1023, 1023, 1'b0);
        queue_write(1, 100, 100, 50, 50, 1'b1);
        queue_write(2, 0, 0, 1023, 1023, 1'b1);
        for (i = 3; i < DEPTH - 1; i++)
            queue_write(i, $urandom_range(0, 1023), $urandom_range(0, 1023),
                        $urandom_range(0, 1023), $urandom_range(0, 1023), roll(50));
        queue_write(15, 1023, 1023, 1023, 1023, 1'b1);

        apply_setting(320, 240, DEPTH, 2, 32'd4, IDLE_NONE);
        // Three untouched samples end the press still held from the reset phase,
        // short of the screensaver timeout.
        force_drain = 1'b1;
        for (i = 0; i < 3; i++)
            queue_sample(1'b0, 2000, 2000);
        // The first touch scales to pixel (125, 125) inside entry 1; the inactive
        // entry 0 in front of it must be skipped.
        queue_sample(1'b1, 1498, 1938);
        queue_sample(1'b1, 4095, 0);
        for (i = 0; i < 3; i++)
            queue_sample(1'b0, 0, 4095);
        // Pixel (100, 125) sits on the left edge of entry 1, so only the catch-all hits.
        queue_sample(1'b1, 1229, 1938);
        // Four untouched samples release the press and then start the screensaver.
        for (i = 0; i < 4; i++)
            queue_sample(1'b0, 2000, 2000);
        // The next touch only wakes; the one after starts a fresh press.
        queue_sample(1'b1, 1498, 1938);
        queue_sample(1'b1, 1498, 1938);

        for (p = 0; p < 8; p++)
        begin
            case (p)
                0: apply_setting(320, 240, DEPTH, 3, 32'd0, IDLE_NONE);
                1: apply_setting(1023, 1023, DEPTH, 0, 32'd1, IDLE_SENDER);
                2: apply_setting(1, 1, 5, 7, 32'd3, IDLE_RECEIVER);
                3: apply_setting($urandom_range(1, 1023), $urandom_range(1, 1023),
                                 $urandom_range(0, DEPTH), 255, 32'hFFFF_FFFF, IDLE_BOTH);
                4: apply_setting($urandom_range(1, 1023), $urandom_range(1, 1023), 0,
                                 $urandom_range(0, 12), 32'($urandom_range(1, 12)),
                                 IDLE_NONE);
                default: apply_setting($urandom_range(1, 1023), $urandom_range(1, 1023),
                                       $urandom_range(0, DEPTH), $urandom_range(0, 12),
                                       32'($urandom_range(0, 30)), idle_mode_e'(p % 4));
            endcase
            run_random_phase(ITEMS_PER_PHASE);
        end

        wait_idle();
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
